// ===== hw/rtl/point_box_clusterer_defines.svh =====
// ----------------------------------------------------------------------------
// point_box_clusterer_defines
// Assertion macros used by the point box clusterer RTL.
// ----------------------------------------------------------------------------
// Both macros sample on clock and are disabled while reset is high.
`ifndef POINT_BOX_CLUSTERER_DEFINES_SVH
`define POINT_BOX_CLUSTERER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define PBC_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("point_box_clusterer: same-cycle check failed");

// Next-cycle implication
`define PBC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("point_box_clusterer: next-cycle check failed");

`else

`define PBC_ASSERT_IMPLIES(label, ante, cons)
`define PBC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/pbc_pkg.sv =====
// ----------------------------------------------------------------------------
// pbc_pkg
// Types and constants shared by the point box clusterer modules.
// ----------------------------------------------------------------------------
package pbc_pkg;

   // Field widths
   localparam int unsigned POS_W       = 12;
   localparam int unsigned TAG_W       = 8;
   localparam int unsigned DIM_W       = 13;
   localparam int unsigned MARGIN_W    = 8;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned BOX_INDEX_W = 7;

   // Stream and register port widths
   localparam int unsigned REQ_TDATA_W = 32;
   localparam int unsigned RSP_TDATA_W = 96;
   localparam int unsigned RSP_TUSER_W = 2;
   localparam int unsigned CSR_ADDR_W  = 4;
   localparam int unsigned CSR_DATA_W  = 32;

   // Register reset values
   localparam logic [MARGIN_W-1:0] MARGIN_RST       = 8'd8;
   localparam logic [DIM_W-1:0]    IMAGE_WIDTH_RST  = 13'd752;
   localparam logic [DIM_W-1:0]    IMAGE_HEIGHT_RST = 13'd480;
   localparam logic [COUNT_W-1:0]  BOX_CAPACITY_RST = 16'd240;

   // Register indexes (byte address divided by four)
   typedef enum logic [1:0] {
      REG_MARGIN       = 2'd0,
      REG_IMAGE_WIDTH  = 2'd1,
      REG_IMAGE_HEIGHT = 2'd2,
      REG_BOX_CAPACITY = 2'd3
   } pbc_reg_type;

   // Scan sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_OPEN
   } pbc_state_type;

   typedef struct packed {
      logic [MARGIN_W-1:0] margin;
      logic [DIM_W-1:0]    image_width;
      logic [DIM_W-1:0]    image_height;
      logic [COUNT_W-1:0]  box_capacity;
   } pbc_cfg_type;

   typedef struct packed {
      logic             start_frame;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [TAG_W-1:0] time_tag;
   } pbc_item_type;

   // One box table entry
   typedef struct packed {
      logic [POS_W-1:0]   left;
      logic [DIM_W-1:0]   right;
      logic [POS_W-1:0]   top;
      logic [DIM_W-1:0]   bottom;
      logic [COUNT_W-1:0] count;
   } pbc_entry_type;

   // Placement decision handed from the scanner to the alignment stages
   typedef struct packed {
      logic                   found;
      logic                   opened;
      logic [BOX_INDEX_W-1:0] box_index;
      logic [POS_W-1:0]       pos_x;
      logic [POS_W-1:0]       pos_y;
      logic [TAG_W-1:0]       time_tag;
      logic [POS_W-1:0]       left;
      logic [DIM_W-1:0]       right;
      logic [POS_W-1:0]       top;
      logic [DIM_W-1:0]       bottom;
   } pbc_res_type;

   // Result beat fields
   typedef struct packed {
      logic                   accepted;
      logic                   opened_box;
      logic [BOX_INDEX_W-1:0] box_index;
      logic [POS_W-1:0]       rel_x;
      logic [POS_W-1:0]       rel_y;
      logic [TAG_W-1:0]       time_out;
      logic [DIM_W-1:0]       aligned_left;
      logic [DIM_W-1:0]       aligned_right;
      logic [DIM_W-1:0]       aligned_top;
      logic [DIM_W-1:0]       aligned_bottom;
   } pbc_out_type;

endpackage

// ===== hw/rtl/pbc_csr.sv =====
// ----------------------------------------------------------------------------
// pbc_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module pbc_csr
   import pbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output pbc_cfg_type           cfg
);

   pbc_cfg_type cfg_ff;
   pbc_reg_type reg_sel;
   logic        wr_en;

   assign reg_sel    = pbc_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Write the selected register in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.margin       <= MARGIN_RST;
         cfg_ff.image_width  <= IMAGE_WIDTH_RST;
         cfg_ff.image_height <= IMAGE_HEIGHT_RST;
         cfg_ff.box_capacity <= BOX_CAPACITY_RST;
      end else if (wr_en) begin
         case (reg_sel)
            REG_MARGIN:       cfg_ff.margin       <= csr_pwdata[MARGIN_W-1:0];
            REG_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT: cfg_ff.image_height <= csr_pwdata[DIM_W-1:0];
            REG_BOX_CAPACITY: cfg_ff.box_capacity <= csr_pwdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Read back the selected register
   always_comb begin
      case (reg_sel)
         REG_MARGIN:       csr_prdata = CSR_DATA_W'(cfg_ff.margin);
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.image_height);
         REG_BOX_CAPACITY: csr_prdata = CSR_DATA_W'(cfg_ff.box_capacity);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/pbc_scan.sv =====
// ----------------------------------------------------------------------------
// pbc_scan
// Box table memory and the sequencer that places each point in a box.
// ----------------------------------------------------------------------------
`include "point_box_clusterer_defines.svh"

module pbc_scan
   import pbc_pkg::*;
#(
   parameter int unsigned MAX_BOXES = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  pbc_cfg_type  cfg,
   input  logic         req_valid,
   output logic         req_ready,
   input  pbc_item_type in_item,
   output logic         res_valid,
   input  logic         res_ready,
   output pbc_res_type  res
);

   localparam int unsigned IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);

   // Box table, one entry per box, synchronous read
   pbc_entry_type box_mem [MAX_BOXES];

   pbc_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] chk_ff, chk_in;
   logic [POS_W-1:0] x_ff, y_ff;
   logic [TAG_W-1:0] tag_ff;
   pbc_entry_type    new_ent_ff, new_ent_in;
   pbc_entry_type    rdata_ff;

   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   pbc_entry_type    wr_data;
   logic [CNT_W-1:0] eff_cnt;
   logic             hit, last, room, accept;

   // New-box edges from the incoming point
   logic [8:0]       reach;
   logic [DIM_W-1:0] x_hi, y_hi, w_lim, h_lim;

   assign reach = {cfg.margin, 1'b0};
   assign x_hi  = DIM_W'(in_item.pos_x) + DIM_W'(reach);
   assign y_hi  = DIM_W'(in_item.pos_y) + DIM_W'(reach);
   assign w_lim = (cfg.image_width != '0) ? cfg.image_width - DIM_W'(1) : '0;
   assign h_lim = (cfg.image_height != '0) ? cfg.image_height - DIM_W'(1) : '0;

   always_comb begin
      new_ent_in.left   = (in_item.pos_x > POS_W'(reach)) ?
                          in_item.pos_x - POS_W'(reach) : '0;
      new_ent_in.right  = (x_hi < w_lim) ? x_hi : w_lim;
      new_ent_in.top    = (in_item.pos_y > POS_W'(reach)) ?
                          in_item.pos_y - POS_W'(reach) : '0;
      new_ent_in.bottom = (y_hi < h_lim) ? y_hi : h_lim;
      new_ent_in.count  = COUNT_W'(1);
   end

   // Match the entry read last cycle against the held point
   assign hit = ({1'b0, x_ff} > DIM_W'(rdata_ff.left)) && ({1'b0, x_ff} < rdata_ff.right) &&
                ({1'b0, y_ff} > DIM_W'(rdata_ff.top))  && ({1'b0, y_ff} < rdata_ff.bottom) &&
                (rdata_ff.count < cfg.box_capacity);
   assign last    = (CNT_W'(chk_ff) + CNT_W'(1)) == cnt_ff;
   assign room    = cnt_ff < CNT_W'(MAX_BOXES);
   assign eff_cnt = in_item.start_frame ? '0 : cnt_ff;
   assign accept  = req_valid && req_ready;

   // Next state, memory strobes and the result beat
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      chk_in    = chk_ff;
      req_ready = (state_ff == ST_IDLE);
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = chk_ff;
      wr_data   = rdata_ff;
      res_valid = 1'b0;
      res       = '0;
      res.pos_x    = x_ff;
      res.pos_y    = y_ff;
      res.time_tag = tag_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cnt_in = eff_cnt;
               chk_in = '0;
               if (eff_cnt == '0) begin
                  state_in = ST_OPEN;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               res_valid     = 1'b1;
               res.found     = 1'b1;
               res.box_index = BOX_INDEX_W'(chk_ff);
               res.left      = rdata_ff.left;
               res.right     = rdata_ff.right;
               res.top       = rdata_ff.top;
               res.bottom    = rdata_ff.bottom;
               if (res_ready) begin
                  wr_en         = 1'b1;
                  wr_data.count = rdata_ff.count + COUNT_W'(1);
                  state_in      = ST_IDLE;
               end
            end else if (last) begin
               state_in = ST_OPEN;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = chk_ff + IDX_W'(1);
               chk_in   = chk_ff + IDX_W'(1);
            end
         end
         ST_OPEN: begin
            res_valid = 1'b1;
            if (room) begin
               res.found     = 1'b1;
               res.opened    = 1'b1;
               res.box_index = BOX_INDEX_W'(cnt_ff[IDX_W-1:0]);
               res.left      = new_ent_ff.left;
               res.right     = new_ent_ff.right;
               res.top       = new_ent_ff.top;
               res.bottom    = new_ent_ff.bottom;
            end
            if (res_ready) begin
               if (room) begin
                  wr_en   = 1'b1;
                  wr_addr = cnt_ff[IDX_W-1:0];
                  wr_data = new_ent_ff;
                  cnt_in  = cnt_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         chk_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         chk_ff   <= chk_in;
      end
   end

   // Hold the point for the whole scan
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff       <= in_item.pos_x;
         y_ff       <= in_item.pos_y;
         tag_ff     <= in_item.time_tag;
         new_ent_ff <= new_ent_in;
      end
   end

   // Box table port: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         box_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= box_mem[rd_addr];
      end
   end

   `PBC_ASSERT_IMPLIES(a_no_rw_clash, rd_en && wr_en, rd_addr != wr_addr)
   `PBC_ASSERT_IMPLIES(a_cnt_range, 1'b1, cnt_ff <= CNT_W'(MAX_BOXES))
   `PBC_ASSERT_IMPLIES(a_wr_on_emit, wr_en, res_valid && res_ready)
   `PBC_ASSERT_IMPLIES(a_scan_stored, state_ff == ST_SCAN, CNT_W'(chk_ff) < cnt_ff)
   `PBC_ASSERT_NEXT(a_frame_clear, accept && in_item.start_frame, cnt_ff == '0)

endmodule

// ===== hw/rtl/pbc_align.sv =====
// ----------------------------------------------------------------------------
// pbc_align
// Tile alignment of box bounds and the result output register.
// ----------------------------------------------------------------------------
module pbc_align
   import pbc_pkg::*;
#(
   parameter int unsigned TILE_W = 16,
   parameter int unsigned TILE_H = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  pbc_cfg_type cfg,
   input  logic        res_valid,
   output logic        res_ready,
   input  pbc_res_type res,
   output logic        out_valid,
   input  logic        out_ready,
   output pbc_out_type out_beat
);

   // Reciprocal divide, exact for dividends below 2^DIV_N and tiles up to 64
   localparam int unsigned DIV_N  = 14;
   localparam int unsigned QSH    = DIV_N + 6;
   localparam int unsigned PROD_W = DIV_N + QSH + 1;
   localparam int unsigned MUL_W  = DIV_N + 7;
   localparam int unsigned RECIP_W = ((1 << QSH) + TILE_W - 1) / TILE_W;
   localparam int unsigned RECIP_H = ((1 << QSH) + TILE_H - 1) / TILE_H;

   logic              s1_vld_ff, out_vld_ff;
   pbc_res_type       s1_res_ff;
   logic [DIV_N-1:0]  ql_ff, qr_ff, qt_ff, qb_ff;
   pbc_out_type       out_ff, out_in;
   logic              load1, adv2;

   logic [DIV_N-1:0]  sum_r, sum_b;
   logic [PROD_W-1:0] prod_l, prod_r, prod_t, prod_b;
   logic [MUL_W-1:0]  al_full, ar_full, at_full, ab_full;
   logic [DIM_W-1:0]  al, ar_raw, at, ab_raw;

   assign adv2      = s1_vld_ff && (!out_vld_ff || out_ready);
   assign res_ready = !s1_vld_ff || adv2;
   assign load1     = res_valid && res_ready;
   assign out_valid = out_vld_ff;
   assign out_beat  = out_ff;

   // Stage 1: tile quotients of the edges (right and bottom rounded up)
   assign sum_r  = DIV_N'(res.right) + DIV_N'(TILE_W - 1);
   assign sum_b  = DIV_N'(res.bottom) + DIV_N'(TILE_H - 1);
   assign prod_l = PROD_W'(res.left) * PROD_W'(RECIP_W);
   assign prod_r = PROD_W'(sum_r) * PROD_W'(RECIP_W);
   assign prod_t = PROD_W'(res.top) * PROD_W'(RECIP_H);
   assign prod_b = PROD_W'(sum_b) * PROD_W'(RECIP_H);

   always_ff @(posedge clock) begin
      if (load1) begin
         s1_res_ff <= res;
         ql_ff     <= prod_l[QSH +: DIV_N];
         qr_ff     <= prod_r[QSH +: DIV_N];
         qt_ff     <= prod_t[QSH +: DIV_N];
         qb_ff     <= prod_b[QSH +: DIV_N];
      end
   end

   // Stage 2: back to pixels, clamp to the image, offset the point
   assign al_full = MUL_W'(ql_ff) * MUL_W'(TILE_W);
   assign ar_full = MUL_W'(qr_ff) * MUL_W'(TILE_W);
   assign at_full = MUL_W'(qt_ff) * MUL_W'(TILE_H);
   assign ab_full = MUL_W'(qb_ff) * MUL_W'(TILE_H);
   assign al      = al_full[DIM_W-1:0];
   assign ar_raw  = ar_full[DIM_W-1:0];
   assign at      = at_full[DIM_W-1:0];
   assign ab_raw  = ab_full[DIM_W-1:0];

   always_comb begin
      out_in          = '0;
      out_in.time_out = s1_res_ff.time_tag;
      if (s1_res_ff.found) begin
         out_in.accepted       = 1'b1;
         out_in.opened_box     = s1_res_ff.opened;
         out_in.box_index      = s1_res_ff.box_index;
         out_in.rel_x          = POS_W'({1'b0, s1_res_ff.pos_x} - al);
         out_in.rel_y          = POS_W'({1'b0, s1_res_ff.pos_y} - at);
         out_in.aligned_left   = al;
         out_in.aligned_right  = (ar_raw < cfg.image_width) ? ar_raw : cfg.image_width;
         out_in.aligned_top    = at;
         out_in.aligned_bottom = (ab_raw < cfg.image_height) ? ab_raw : cfg.image_height;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         out_ff <= out_in;
      end
   end

   // Stage occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (load1) begin
            s1_vld_ff <= 1'b1;
         end else if (adv2) begin
            s1_vld_ff <= 1'b0;
         end
         if (adv2) begin
            out_vld_ff <= 1'b1;
         end else if (out_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== hw/rtl/point_box_clusterer.sv =====
// ----------------------------------------------------------------------------
// point_box_clusterer
// Groups sorted image points into boxes and reports tile-aligned bounds.
// ----------------------------------------------------------------------------
// Each point is checked against the stored boxes one table entry per clock,
// reading the box table memory in order from box 0; it joins the first box
// that strictly contains it and still has room, or else opens a new box, or
// is dropped when the table is full. A point that joins box k holds off the
// next point while entries 0 to k are read; a point that opens a box or is
// dropped first reads every stored box, none at the start of a frame. The
// result is registered in the quotient stage and then the output stage of
// the alignment, and the next point is taken while a result waits on rsp_tready.
// The table is cleared by the start-of-frame flag (req_tuser), with no
// clearing pass after reset.
module point_box_clusterer
   import pbc_pkg::*;
#(
   parameter int unsigned MAX_BOXES = 128,
   parameter int unsigned TILE_W    = 16,
   parameter int unsigned TILE_H    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // Point beats
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // pos_x, pos_y, time_tag
   input  logic                   req_tuser,  // start_frame
   // Result beats
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // box_index, rel_x, rel_y, time_out,
                                              // aligned_left, aligned_right,
                                              // aligned_top, aligned_bottom, zero pad
   output logic [RSP_TUSER_W-1:0] rsp_tuser,  // accepted, opened_box
   // Configuration
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   pbc_cfg_type  cfg;
   pbc_item_type item;
   pbc_res_type  res;
   pbc_out_type  out_beat;
   logic         res_valid, res_ready;

   // Unpack the point beat
   assign item.start_frame = req_tuser;
   assign item.pos_x       = req_tdata[11:0];
   assign item.pos_y       = req_tdata[23:12];
   assign item.time_tag    = req_tdata[31:24];

   pbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pbc_scan #(
      .MAX_BOXES (MAX_BOXES)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .in_item   (item),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   pbc_align #(
      .TILE_W (TILE_W),
      .TILE_H (TILE_H)
   ) u_align (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_beat  (out_beat)
   );

   // Pack the result beat, first field lowest
   assign rsp_tuser = {out_beat.opened_box, out_beat.accepted};
   assign rsp_tdata = {5'b0,
                       out_beat.aligned_bottom,
                       out_beat.aligned_top,
                       out_beat.aligned_right,
                       out_beat.aligned_left,
                       out_beat.time_out,
                       out_beat.rel_y,
                       out_beat.rel_x,
                       out_beat.box_index};

endmodule

// ===== tb/point_box_clusterer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_box_clusterer_tb
// Self-checking bench for the point box clusterer.
// ----------------------------------------------------------------------------
// Point beats go in on the request stream, and an internal box table model
// predicts the placement of each point. Every result beat is then checked
// field by field against the oldest prediction. The run covers a directed
// set of edge points and then register settings from the extremes to random
// ones. Each setting carries a random mix of sorted frames of clustered points,
// frames broken by stray points, scattered noise and frames long enough to fill
// the table. Both streams idle at random, and once per setting the result
// side holds off long enough to back up the request side.
module point_box_clusterer_tb;
   import pbc_pkg::*;

   localparam int unsigned BOX_SLOTS    = 128;
   localparam int unsigned TILE_SIZE    = 16;
   localparam int unsigned PHASE_POINTS = 160;
   localparam int unsigned HOLD_CYCLES  = 300;

   // Box table model and store of awaited result beats
   class placement_scoreboard;
      int unsigned margin;
      int unsigned image_width;
      int unsigned image_height;
      int unsigned box_capacity;
      int unsigned box_left[BOX_SLOTS];
      int unsigned box_right[BOX_SLOTS];
      int unsigned box_top[BOX_SLOTS];
      int unsigned box_bottom[BOX_SLOTS];
      int unsigned box_fill[BOX_SLOTS];
      int unsigned boxes_open;
      pbc_out_type awaited[$];
      int unsigned errors;

      function new();
         margin       = MARGIN_RST;
         image_width  = IMAGE_WIDTH_RST;
         image_height = IMAGE_HEIGHT_RST;
         box_capacity = BOX_CAPACITY_RST;
         boxes_open   = 0;
         errors       = 0;
      endfunction

      function void set_register(pbc_reg_type idx, int unsigned value);
         case (idx)
            REG_MARGIN:       margin       = value & 32'hFF;
            REG_IMAGE_WIDTH:  image_width  = value & 32'h1FFF;
            REG_IMAGE_HEIGHT: image_height = value & 32'h1FFF;
            REG_BOX_CAPACITY: box_capacity = value & 32'hFFFF;
            default: ;
         endcase
      endfunction

      // Place one accepted point and queue the result it must produce
      function void place_point(pbc_item_type pt);
         int unsigned x, y, reach, idx, right_lim, bottom_lim, al, ar, at, ab;
         bit found, opened;
         pbc_out_type want;
         x      = pt.pos_x;
         y      = pt.pos_y;
         reach  = 2 * margin;
         idx    = 0;
         found  = 1'b0;
         opened = 1'b0;
         if (pt.start_frame) begin
            boxes_open = 0;
         end
         // first stored box that strictly contains the point and has room
         for (int i = 0; i < boxes_open; i++) begin
            if (!found && x > box_left[i] && x < box_right[i] && y > box_top[i] &&
                y < box_bottom[i] && box_fill[i] < box_capacity) begin
               box_fill[i]++;
               idx   = i;
               found = 1'b1;
            end
         end
         // otherwise open a new box, clamped to the image
         if (!found && boxes_open < BOX_SLOTS) begin
            right_lim  = (image_width > 1) ? image_width - 1 : 0;
            bottom_lim = (image_height > 1) ? image_height - 1 : 0;
            idx = boxes_open;
            box_left[idx]   = (x > reach) ? x - reach : 0;
            box_right[idx]  = (x + reach < right_lim) ? x + reach : right_lim;
            box_top[idx]    = (y > reach) ? y - reach : 0;
            box_bottom[idx] = (y + reach < bottom_lim) ? y + reach : bottom_lim;
            box_fill[idx]   = 1;
            boxes_open++;
            found  = 1'b1;
            opened = 1'b1;
         end
         want = '0;
         want.time_out = pt.time_tag;
         if (found) begin
            al = (box_left[idx] / TILE_SIZE) * TILE_SIZE;
            ar = ((box_right[idx] + TILE_SIZE - 1) / TILE_SIZE) * TILE_SIZE;
            at = (box_top[idx] / TILE_SIZE) * TILE_SIZE;
            ab = ((box_bottom[idx] + TILE_SIZE - 1) / TILE_SIZE) * TILE_SIZE;
            if (ar > image_width) ar = image_width;
            if (ab > image_height) ab = image_height;
            want.accepted       = 1'b1;
            want.opened_box     = opened;
            want.box_index      = idx[BOX_INDEX_W-1:0];
            want.rel_x          = 12'(x - al);
            want.rel_y          = 12'(y - at);
            want.aligned_left   = 13'(al);
            want.aligned_right  = 13'(ar);
            want.aligned_top    = 13'(at);
            want.aligned_bottom = 13'(ab);
         end
         awaited.push_back(want);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
         end
      endfunction

      // Check one result beat against the oldest prediction
      function void check_result(pbc_out_type got);
         pbc_out_type want;
         if (awaited.size() == 0) begin
            $error("result beat with nothing awaited: box_index %0d, time_out %0d",
                   got.box_index, got.time_out);
            errors++;
            return;
         end
         want = awaited.pop_front();
         compare("accepted",       want.accepted,       got.accepted);
         compare("opened_box",     want.opened_box,     got.opened_box);
         compare("box_index",      want.box_index,      got.box_index);
         compare("rel_x",          want.rel_x,          got.rel_x);
         compare("rel_y",          want.rel_y,          got.rel_y);
         compare("time_out",       want.time_out,       got.time_out);
         compare("aligned_left",   want.aligned_left,   got.aligned_left);
         compare("aligned_right",  want.aligned_right,  got.aligned_right);
         compare("aligned_top",    want.aligned_top,    got.aligned_top);
         compare("aligned_bottom", want.aligned_bottom, got.aligned_bottom);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;  // pos_x, pos_y, time_tag
   logic                   req_tuser;  // start_frame
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // box_index, rel_x, rel_y, time_out, aligned_left,
                                       // aligned_right, aligned_top, aligned_bottom, pad
   logic [RSP_TUSER_W-1:0] rsp_tuser;  // accepted, opened_box
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   placement_scoreboard board;
   int unsigned         points_sent = 0;
   bit                  hold_off_req = 1'b0;

   point_box_clusterer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Offer one point beat and note it once it is taken
   task automatic send_point(input bit first, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic [TAG_W-1:0] tag);
      pbc_item_type pt;
      pt.start_frame = first;
      pt.pos_x       = x;
      pt.pos_y       = y;
      pt.time_tag    = tag;
      // idle at random, except for a steady stretch in the middle of the run
      while (!(points_sent >= 600 && points_sent < 900) && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= pt.start_frame;
      req_tdata  <= {pt.time_tag, pt.pos_y, pt.pos_x};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      board.place_point(pt);
      @(posedge clock);
      points_sent++;
   endtask

   function automatic logic [POS_W-1:0] clamp_pos(int signed v);
      if (v < 0) return '0;
      if (v > 4095) return 12'd4095;
      return v[POS_W-1:0];
   endfunction

   function automatic int unsigned dim_span(int unsigned d);
      if (d == 0) return 1;
      return (d > 4096) ? 4096 : d;
   endfunction

   // Sorted frame of points clustered around a few seeds
   task automatic send_frame(input bit broken);
      bit [31:0]   keys[$];
      int unsigned n_points, n_seeds, spread, c;
      int unsigned sx[6];
      int unsigned sy[6];
      int signed   dx, dy;
      n_points = $urandom_range(40, 4);
      n_seeds  = $urandom_range(6, 1);
      spread   = 2 * board.margin + 1;
      for (int i = 0; i < n_seeds; i++) begin
         sx[i] = $urandom_range(dim_span(board.image_width) - 1);
         sy[i] = $urandom_range(dim_span(board.image_height) - 1);
      end
      for (int i = 0; i < n_points; i++) begin
         c  = $urandom_range(n_seeds - 1);
         dx = int'($urandom_range(2 * spread)) - int'(spread);
         dy = int'($urandom_range(2 * spread)) - int'(spread);
         keys.push_back({clamp_pos(int'(sy[c]) + dy), clamp_pos(int'(sx[c]) + dx),
                         8'($urandom)});
      end
      // ascending row, then column
      keys.sort();
      if (broken) begin
         repeat ($urandom_range(3, 1)) keys.insert($urandom_range(keys.size()), $urandom);
      end
      foreach (keys[i]) send_point(i == 0, keys[i][19:8], keys[i][31:20], keys[i][7:0]);
   endtask

   // Unordered points; a frame flag now and then when odds is non-zero
   task automatic send_scatter(input int unsigned n, input int unsigned odds);
      repeat (n) begin
         send_point(odds != 0 && $urandom_range(odds - 1) == 0,
                    12'($urandom), 12'($urandom), 8'($urandom));
      end
   endtask

   // One frame longer than the table, so the tail is dropped
   task automatic send_long_frame();
      send_point(1'b1, 12'($urandom), 12'($urandom), 8'($urandom));
      send_scatter(BOX_SLOTS + 8, 0);
   endtask

   task automatic write_register(input pbc_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.set_register(idx, value);
      // leave the port idle before the next transfer
      @(posedge clock);
   endtask

   // Stop offering and wait until every awaited beat is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Result side: random stalls, a steady stretch, and long hold-offs on request
   initial begin
      int unsigned cycle_no;
      cycle_no   = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle_no++;
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            cycle_no += HOLD_CYCLES;
            hold_off_req = 1'b0;
         end else if ((cycle_no >= 40000 && cycle_no < 70000) || $urandom_range(99) >= 25) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
         end
      end
   end

   // Take each result beat while it is stable, ahead of the edge that moves it
   always @(negedge clock) begin
      pbc_out_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.accepted       = rsp_tuser[0];
         got.opened_box     = rsp_tuser[1];
         got.box_index      = rsp_tdata[6:0];
         got.rel_x          = rsp_tdata[18:7];
         got.rel_y          = rsp_tdata[30:19];
         got.time_out       = rsp_tdata[38:31];
         got.aligned_left   = rsp_tdata[51:39];
         got.aligned_right  = rsp_tdata[64:52];
         got.aligned_top    = rsp_tdata[77:65];
         got.aligned_bottom = rsp_tdata[90:78];
         board.check_result(got);
      end
   end

   // Main sequence
   initial begin
      pbc_cfg_type setting;
      int unsigned phase_start, mode;
      board = new();
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Edge points under the reset settings
      send_point(1'b1, 12'd0, 12'd0, 8'd0);            // top-left clamp saturates
      send_point(1'b0, 12'd1, 12'd1, 8'hFF);           // joins the box above
      send_point(1'b0, 12'd16, 12'd16, 8'h01);         // on the box edge, opens another
      send_point(1'b0, 12'd100, 12'd100, 8'h10);
      send_point(1'b0, 12'd101, 12'd102, 8'h11);
      send_point(1'b0, 12'd115, 12'd115, 8'h12);
      send_point(1'b0, 12'd84, 12'd100, 8'h13);        // left edge, not inside
      send_point(1'b0, 12'd751, 12'd479, 8'h20);       // right and bottom clamp
      send_point(1'b0, 12'd4095, 12'd0, 8'h21);
      send_point(1'b0, 12'd4095, 12'd4095, 8'hAA);     // outside the image
      send_point(1'b0, 12'hAAA, 12'h555, 8'h55);
      send_point(1'b0, 12'h555, 12'hAAA, 8'hAA);
      send_point(1'b1, 12'd200, 12'd200, 8'h30);       // frame flag clears the table
      send_point(1'b0, 12'd201, 12'd201, 8'h31);
      send_point(1'b0, 12'd0, 12'd4095, 8'h80);
      drain_results();

      for (int phase = 0; phase < 9; phase++) begin
         // Settings: the extremes first, then random ones
         case (phase)
            0: setting = '{margin: 8'd0,   image_width: 13'd4096, image_height: 13'd4096,
                           box_capacity: 16'd65535};
            1: setting = '{margin: 8'd255, image_width: 13'd1,    image_height: 13'd1,
                           box_capacity: 16'd1};
            2: setting = '{margin: 8'd200, image_width: 13'd0,    image_height: 13'd8191,
                           box_capacity: 16'd0};
            3: setting = '{margin: 8'd3,   image_width: 13'd8191, image_height: 13'd0,
                           box_capacity: 16'd2};
            default: begin
               setting.margin       = 8'($urandom_range(24, 1));
               setting.image_width  = 13'($urandom_range(4096, 16));
               setting.image_height = 13'($urandom_range(4096, 16));
               setting.box_capacity = ($urandom_range(3) == 0) ?
                                      16'($urandom_range(65535, 1000)) :
                                      16'($urandom_range(6, 1));
            end
         endcase
         drain_results();
         write_register(REG_MARGIN,       32'(setting.margin));
         write_register(REG_IMAGE_WIDTH,  32'(setting.image_width));
         write_register(REG_IMAGE_HEIGHT, 32'(setting.image_height));
         write_register(REG_BOX_CAPACITY, 32'(setting.box_capacity));

         // Back up the request side once per setting
         hold_off_req = 1'b1;
         phase_start  = points_sent;
         if (phase == 0 || phase == 2) begin
            send_long_frame();
         end
         while (points_sent - phase_start < PHASE_POINTS) begin
            mode = $urandom_range(19);
            if (mode < 14) begin
               send_frame(1'b0);
            end else if (mode < 17) begin
               send_frame(1'b1);
            end else if (mode < 19) begin
               send_scatter($urandom_range(30, 10), 16);
            end else begin
               send_long_frame();
            end
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Hard limit on the run
   initial begin
      #25_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
